// ===== src/bmis_pkg.sv =====
package bmis_pkg;

  localparam int unsigned AddrWidth = 16;

  localparam int unsigned OpWidth    = 16;
  localparam int unsigned FieldWidth = 16;
  localparam int unsigned OffWidth   = 17;
  localparam int unsigned KindWidth  = 3;
  localparam int unsigned InBits     = 56;
  localparam int unsigned OutBits    = 40;

  localparam logic [15:0] SkipCell    = 16'hFFF0;
  localparam logic [15:0] BranchCell  = 16'hFFF1;
  localparam logic [15:0] DistCell    = 16'hFFE0;
  localparam logic [15:0] NewlineCode = 16'h0013;
  localparam logic [15:0] NewlineChar = 16'h000A;

  localparam int unsigned NumBits  = 7;
  localparam int unsigned DistBits = 16;
  localparam int unsigned IdxWidth = $clog2(DistBits);

  localparam logic [OffWidth-1:0] AdvShort = 17'd8;
  localparam logic [OffWidth-1:0] AdvLong  = 17'd12;

  localparam logic [OpWidth-1:0] OpClr    = 16'h0000;
  localparam logic [OpWidth-1:0] OpSet    = 16'h0001;
  localparam logic [OpWidth-1:0] OpInv    = 16'h0002;
  localparam logic [OpWidth-1:0] OpXor    = 16'h0003;
  localparam logic [OpWidth-1:0] OpOr     = 16'h0004;
  localparam logic [OpWidth-1:0] OpAnd    = 16'h0005;
  localparam logic [OpWidth-1:0] OpMov    = 16'h0006;
  localparam logic [OpWidth-1:0] OpPrtBit = 16'hF000;
  localparam logic [OpWidth-1:0] OpPrtChr = 16'hF001;
  localparam logic [OpWidth-1:0] OpPrtNum = 16'hF002;
  localparam logic [OpWidth-1:0] OpKey    = 16'hF003;
  localparam logic [OpWidth-1:0] OpHalt   = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_BIT,
    KIND_CHAR,
    KIND_NEWLINE,
    KIND_NUMBER,
    KIND_HALT
  } kind_e;

  typedef logic [4:0] upc_t;

  localparam upc_t UIdle  = 5'd0;
  localparam upc_t UBr    = 5'd1;
  localparam upc_t USkip  = 5'd2;
  localparam upc_t UWr    = 5'd3;
  localparam upc_t URa    = 5'd4;
  localparam upc_t UInv   = 5'd5;
  localparam upc_t URb    = 5'd6;
  localparam upc_t UBin   = 5'd7;
  localparam upc_t UPbit  = 5'd8;
  localparam upc_t UNrd   = 5'd9;
  localparam upc_t UNloop = 5'd10;
  localparam upc_t UNlast = 5'd11;
  localparam upc_t UBrclr = 5'd12;
  localparam upc_t UDrd   = 5'd13;
  localparam upc_t UDloop = 5'd14;
  localparam upc_t UDlast = 5'd15;
  localparam upc_t UOut   = 5'd16;

  typedef enum logic [2:0] {
    AS_BRANCH,
    AS_SKIP,
    AS_A,
    AS_B,
    AS_A_I,
    AS_DIST_I
  } asel_e;

  typedef enum logic [1:0] {
    WD_ZERO,
    WD_OP,
    WD_INV,
    WD_ALU
  } wsel_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_LEFT,
    SH_RIGHT
  } shift_e;

  typedef enum logic [3:0] {
    J_NEXT,
    J_GOTO,
    J_BRANCH,
    J_DISP_RUN,
    J_DISP_READ,
    J_LOOP_NUM,
    J_LOOP_DIST,
    J_IDLE,
    J_OUT
  } jump_e;

  typedef struct packed {
    asel_e  raddr;
    asel_e  waddr;
    logic   we;
    wsel_e  wsel;
    logic   run_ld;
    logic   t_ld;
    logic   br_set;
    logic   i_inc;
    shift_e shift;
    jump_e  jump;
    upc_t   target;
  } ctrl_t;

  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t c;
    c = '0;
    c.raddr  = AS_A;
    c.waddr  = AS_A;
    c.wsel   = WD_ZERO;
    c.shift  = SH_NONE;
    c.jump   = J_NEXT;
    c.target = UIdle;
    case (pc)
      UIdle: begin
        c.raddr = AS_BRANCH;
        c.jump  = J_IDLE;
      end
      UBr: begin
        c.raddr  = AS_SKIP;
        c.jump   = J_BRANCH;
        c.target = UBrclr;
      end
      USkip: begin
        c.waddr  = AS_SKIP;
        c.we     = 1'b1;
        c.run_ld = 1'b1;
        c.jump   = J_DISP_RUN;
      end
      UWr: begin
        c.we     = 1'b1;
        c.wsel   = WD_OP;
        c.jump   = J_GOTO;
        c.target = UOut;
      end
      URa: begin
        c.jump = J_DISP_READ;
      end
      UInv: begin
        c.we     = 1'b1;
        c.wsel   = WD_INV;
        c.jump   = J_GOTO;
        c.target = UOut;
      end
      URb: begin
        c.raddr = AS_B;
        c.t_ld  = 1'b1;
      end
      UBin: begin
        c.we     = 1'b1;
        c.wsel   = WD_ALU;
        c.jump   = J_GOTO;
        c.target = UOut;
      end
      UPbit: begin
        c.t_ld   = 1'b1;
        c.jump   = J_GOTO;
        c.target = UOut;
      end
      UNrd: begin
        c.raddr = AS_A_I;
        c.i_inc = 1'b1;
      end
      UNloop: begin
        c.raddr  = AS_A_I;
        c.i_inc  = 1'b1;
        c.shift  = SH_LEFT;
        c.jump   = J_LOOP_NUM;
        c.target = UNloop;
      end
      UNlast: begin
        c.shift  = SH_LEFT;
        c.jump   = J_GOTO;
        c.target = UOut;
      end
      UBrclr: begin
        c.waddr  = AS_BRANCH;
        c.we     = 1'b1;
        c.br_set = 1'b1;
      end
      UDrd: begin
        c.raddr = AS_DIST_I;
        c.waddr = AS_DIST_I;
        c.we    = 1'b1;
        c.i_inc = 1'b1;
      end
      UDloop: begin
        c.raddr  = AS_DIST_I;
        c.waddr  = AS_DIST_I;
        c.we     = 1'b1;
        c.i_inc  = 1'b1;
        c.shift  = SH_RIGHT;
        c.jump   = J_LOOP_DIST;
        c.target = UDloop;
      end
      UDlast: begin
        c.shift = SH_RIGHT;
      end
      UOut: begin
        c.jump = J_OUT;
      end
      default: begin
        c.jump   = J_GOTO;
        c.target = UIdle;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== src/bit_machine_instruction_step.sv =====
// Executes one bit-machine instruction per item on a single-port-style bit memory of
// 2^ADDR_WIDTH one-bit cells, driven by a small microprogram with one control word per
// cycle. After reset the block sweeps the memory to zero and holds s_axis_tready low
// meanwhile. Once halted, an item goes straight to the output step; otherwise the branch
// cell and then the skip cell are tested, and skipped, unknown, F001 and FFFF items go to
// output at once. The memory gives one read per cycle, which the branch (sixteen distance
// bits) and number print (seven bits) walk through one bit at a time. The next item is
// taken once the result sits in the output register.
module bit_machine_instruction_step #(
  parameter int unsigned ADDR_WIDTH = bmis_pkg::AddrWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // opcode[15:0], addr_a[31:16], addr_b[47:32], key_bit[48], zero fill
  input  logic [bmis_pkg::InBits-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // step_offset[16:0], out_value[32:17], zero fill
  output logic [bmis_pkg::OutBits-1:0]   m_axis_tdata,
  // out_kind[2:0]
  output logic [bmis_pkg::KindWidth-1:0] m_axis_tuser
);

  localparam int unsigned Depth = 1 << ADDR_WIDTH;
  localparam int unsigned OW    = bmis_pkg::OffWidth;
  localparam int unsigned FW    = bmis_pkg::FieldWidth;
  localparam int unsigned IW    = bmis_pkg::IdxWidth;

  localparam logic [ADDR_WIDTH-1:0] CellSkip   = bmis_pkg::SkipCell[ADDR_WIDTH-1:0];
  localparam logic [ADDR_WIDTH-1:0] CellBranch = bmis_pkg::BranchCell[ADDR_WIDTH-1:0];
  localparam logic [ADDR_WIDTH-1:0] CellDist   = bmis_pkg::DistCell[ADDR_WIDTH-1:0];
  localparam logic [IW-1:0]         NumLast    = IW'(bmis_pkg::NumBits - 1);
  localparam logic [IW-1:0]         DistLast   = IW'(bmis_pkg::DistBits - 1);

  logic mem_q [Depth];

  logic                  clr_q, clr_d;
  logic [ADDR_WIDTH-1:0] clr_cnt_q, clr_cnt_d;
  bmis_pkg::upc_t        upc_q, upc_d;
  logic                  halted_q, halted_d;
  logic                  hz_q, hz_d;
  logic                  br_q, br_d;
  logic                  run_q, run_d;
  logic [IW-1:0]         i_q, i_d;
  logic                  out_valid_q, out_valid_d;

  logic [FW-1:0] op_q, a_q, b_q;
  logic          key_q;
  logic [FW-1:0] acc_q, acc_d;
  logic          t_q, t_d;
  logic          rdat_q;
  logic [OW-1:0] out_off_q, out_off_d;
  logic [FW-1:0] out_val_q, out_val_d;
  bmis_pkg::kind_e out_kind_q, out_kind_d;

  bmis_pkg::ctrl_t       ctrl;
  logic                  in_acc;
  logic                  out_load;
  logic [ADDR_WIDTH-1:0] raddr, waddr, uwaddr;
  logic                  we, wd, uwd, alu;

  assign ctrl     = bmis_pkg::ucode(upc_q);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_load = (upc_q == bmis_pkg::UOut) && (!out_valid_q || m_axis_tready);

  assign s_axis_tready = !clr_q && (upc_q == bmis_pkg::UIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_val_q, out_off_q};
  assign m_axis_tuser  = out_kind_q;

  function automatic logic [ADDR_WIDTH-1:0] addr_of(bmis_pkg::asel_e s,
                                                    logic [FW-1:0] a, logic [FW-1:0] b,
                                                    logic [IW-1:0] i);
    logic [ADDR_WIDTH-1:0] r;
    case (s)
      bmis_pkg::AS_BRANCH: r = CellBranch;
      bmis_pkg::AS_SKIP:   r = CellSkip;
      bmis_pkg::AS_A:      r = a[ADDR_WIDTH-1:0];
      bmis_pkg::AS_B:      r = b[ADDR_WIDTH-1:0];
      bmis_pkg::AS_A_I:    r = a[ADDR_WIDTH-1:0] + ADDR_WIDTH'(i);
      bmis_pkg::AS_DIST_I: r = CellDist + ADDR_WIDTH'(i);
      default:             r = CellSkip;
    endcase
    return r;
  endfunction

  always_comb begin
    case (op_q)
      bmis_pkg::OpXor: alu = t_q ^ rdat_q;
      bmis_pkg::OpOr:  alu = t_q | rdat_q;
      bmis_pkg::OpAnd: alu = t_q & rdat_q;
      default:         alu = rdat_q;
    endcase
    case (ctrl.wsel)
      bmis_pkg::WD_ZERO: uwd = 1'b0;
      bmis_pkg::WD_OP:   uwd = (op_q == bmis_pkg::OpSet) ||
                               ((op_q == bmis_pkg::OpKey) && key_q);
      bmis_pkg::WD_INV:  uwd = ~rdat_q;
      bmis_pkg::WD_ALU:  uwd = alu;
      default:           uwd = 1'b0;
    endcase
    raddr  = addr_of(ctrl.raddr, a_q, b_q, i_q);
    uwaddr = addr_of(ctrl.waddr, a_q, b_q, i_q);
    we     = clr_q || ctrl.we;
    waddr  = clr_q ? clr_cnt_q : uwaddr;
    wd     = clr_q ? 1'b0 : uwd;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wd;
    end
    rdat_q <= mem_q[raddr];
  end

  always_comb begin
    clr_d       = clr_q;
    clr_cnt_d   = clr_cnt_q;
    upc_d       = upc_q + 5'd1;
    halted_d    = halted_q;
    hz_d        = hz_q;
    br_d        = br_q || ctrl.br_set;
    run_d       = ctrl.run_ld ? ~rdat_q : run_q;
    i_d         = ctrl.i_inc ? i_q + IW'(1) : i_q;
    out_valid_d = out_valid_q;
    t_d         = ctrl.t_ld ? rdat_q : t_q;
    out_off_d   = out_off_q;
    out_val_d   = out_val_q;
    out_kind_d  = out_kind_q;

    case (ctrl.shift)
      bmis_pkg::SH_LEFT:  acc_d = {acc_q[FW-2:0], rdat_q};
      bmis_pkg::SH_RIGHT: acc_d = {rdat_q, acc_q[FW-1:1]};
      default:            acc_d = acc_q;
    endcase

    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + ADDR_WIDTH'(1);
      if (clr_cnt_q == '1) begin
        clr_d = 1'b0;
      end
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (ctrl.jump)
      bmis_pkg::J_NEXT:   upc_d = upc_q + 5'd1;
      bmis_pkg::J_GOTO:   upc_d = ctrl.target;
      bmis_pkg::J_BRANCH: upc_d = rdat_q ? ctrl.target : upc_q + 5'd1;
      bmis_pkg::J_DISP_RUN: begin
        if (rdat_q) begin
          upc_d = bmis_pkg::UOut;
        end else begin
          case (op_q)
            bmis_pkg::OpClr, bmis_pkg::OpSet, bmis_pkg::OpKey: upc_d = bmis_pkg::UWr;
            bmis_pkg::OpInv, bmis_pkg::OpXor, bmis_pkg::OpOr, bmis_pkg::OpAnd,
            bmis_pkg::OpMov, bmis_pkg::OpPrtBit:                upc_d = bmis_pkg::URa;
            bmis_pkg::OpPrtNum:                                 upc_d = bmis_pkg::UNrd;
            default:                                            upc_d = bmis_pkg::UOut;
          endcase
        end
      end
      bmis_pkg::J_DISP_READ: begin
        case (op_q)
          bmis_pkg::OpInv:    upc_d = bmis_pkg::UInv;
          bmis_pkg::OpPrtBit: upc_d = bmis_pkg::UPbit;
          default:            upc_d = bmis_pkg::URb;
        endcase
      end
      bmis_pkg::J_LOOP_NUM:  upc_d = (i_q != NumLast) ? ctrl.target : upc_q + 5'd1;
      bmis_pkg::J_LOOP_DIST: upc_d = (i_q != DistLast) ? ctrl.target : upc_q + 5'd1;
      bmis_pkg::J_IDLE: begin
        upc_d = bmis_pkg::UIdle;
        if (in_acc) begin
          upc_d = halted_q ? bmis_pkg::UOut : bmis_pkg::UBr;
          hz_d  = halted_q;
          br_d  = 1'b0;
          run_d = 1'b0;
          i_d   = '0;
          acc_d = '0;
        end
      end
      bmis_pkg::J_OUT: begin
        upc_d = out_load ? bmis_pkg::UIdle : bmis_pkg::UOut;
      end
      default: upc_d = bmis_pkg::UIdle;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
      out_kind_d  = bmis_pkg::KIND_NONE;
      out_val_d   = '0;
      if (hz_q) begin
        out_off_d = '0;
      end else if (br_q) begin
        out_off_d = OW'(0) - {1'b0, acc_q};
      end else begin
        if ((op_q == bmis_pkg::OpXor) || (op_q == bmis_pkg::OpOr) ||
            (op_q == bmis_pkg::OpAnd) || (op_q == bmis_pkg::OpMov)) begin
          out_off_d = bmis_pkg::AdvLong;
        end else begin
          out_off_d = bmis_pkg::AdvShort;
        end
        if (run_q) begin
          case (op_q)
            bmis_pkg::OpPrtBit: begin
              out_kind_d = bmis_pkg::KIND_BIT;
              out_val_d  = {{(FW-1){1'b0}}, t_q};
            end
            bmis_pkg::OpPrtChr: begin
              if (a_q == bmis_pkg::NewlineCode) begin
                out_kind_d = bmis_pkg::KIND_NEWLINE;
                out_val_d  = bmis_pkg::NewlineChar;
              end else begin
                out_kind_d = bmis_pkg::KIND_CHAR;
                out_val_d  = {8'd0, a_q[7:0]};
              end
            end
            bmis_pkg::OpPrtNum: begin
              out_kind_d = bmis_pkg::KIND_NUMBER;
              out_val_d  = {{(FW-bmis_pkg::NumBits){1'b0}}, acc_q[bmis_pkg::NumBits-1:0]};
            end
            bmis_pkg::OpHalt: begin
              out_kind_d = bmis_pkg::KIND_HALT;
              out_val_d  = a_q;
              halted_d   = 1'b1;
            end
            default: begin
              out_kind_d = bmis_pkg::KIND_NONE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      upc_q       <= bmis_pkg::UIdle;
      halted_q    <= 1'b0;
      hz_q        <= 1'b0;
      br_q        <= 1'b0;
      run_q       <= 1'b0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      upc_q       <= upc_d;
      halted_q    <= halted_d;
      hz_q        <= hz_d;
      br_q        <= br_d;
      run_q       <= run_d;
      i_q         <= i_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= s_axis_tdata[15:0];
      a_q   <= s_axis_tdata[31:16];
      b_q   <= s_axis_tdata[47:32];
      key_q <= s_axis_tdata[48];
    end
    acc_q      <= acc_d;
    t_q        <= t_d;
    out_off_q  <= out_off_d;
    out_val_q  <= out_val_d;
    out_kind_q <= out_kind_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (upc_q != bmis_pkg::UIdle))
    else $error("accepted item did not start the microprogram");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag dropped without reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(upc_q) == bmis_pkg::UOut))
    else $error("result appeared outside the output step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (upc_q == bmis_pkg::UIdle) && !m_axis_tvalid)
    else $error("activity during memory clearing pass");

endmodule
